/* hw/rtl/pble_pkg.sv */
// Shared types and codes for the positional byte list engine.
`timescale 1ns / 1ps

package pble_pkg;

  // Request codes carried in the low bits of the slave-side tdata.
  typedef enum logic [2:0] {
    REQ_INS_TAIL = 3'd0,
    REQ_INS_HEAD = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_DEL_TAIL = 3'd3,
    REQ_DEL_HEAD = 3'd4,
    REQ_DEL_POS  = 3'd5,
    REQ_SEARCH   = 3'd6
  } req_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_RANGE = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_MISS  = 3'd4
  } status_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_CMP  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic [7:0]  item;
  } cell_ctrl_t;

  // Controller states.
  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_state_e;

endpackage

/* hw/rtl/positional_byte_list_engine_top.sv */
// Top level of the positional byte list engine: request decode, cell chain and result register.
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to DEPTH bytes in a chain of cells,
// one byte per cell, with the head in cell 0. Inserts and deletes are done in
// place: every cell behind the affected position takes the byte of its left
// or right neighbor at the same clock edge, so an insert or delete beat has
// its result registered in the cycle it is accepted. A search takes longer.
// In the accept cycle every cell compares its byte with the key and stores a
// hit flag; a scan counter then walks the hit flags from the head, one cell
// per cycle, and stops at the first hit or at the tail. A search occupies the
// engine until its scan ends, and the slave side deasserts tready during the
// scan. Results leave through a single output register; a new request is
// accepted while that register holds a result only if the master side takes
// the result in the same cycle. Failed requests leave the list unchanged and
// report an error status with item_out and found_index zero. The list_length
// field reports the element count after the request, truncated to five bits.
// The cell contents are not cleared at reset; the length is, so no clearing
// pass is needed.
module positional_byte_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave-side beat, tdata from bit 0: req_type[2:0], item[10:3], position[15:11].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // Master-side beat, tdata from bit 0: status[2:0], item_out[10:3],
  // found_index[15:11], list_length[20:16], zero padding[23:21].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata
);

  // Length register width, cell address width and the width used for
  // comparisons between the length and the five-bit position field.
  localparam int LW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (LW > 5) ? LW : 5;

  // Unpacked request fields.
  logic [2:0] req_type;
  logic [7:0] req_item;
  logic [4:0] req_pos;

  assign req_type = s_axis_tdata[2:0];
  assign req_item = s_axis_tdata[10:3];
  assign req_pos  = s_axis_tdata[15:11];

  // Control state.
  pble_pkg::fsm_state_e state_q, state_d;
  logic [LW-1:0]        len_q, len_d;
  logic [AW-1:0]        cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  // Result register, no reset needed.
  logic [2:0] out_status_q, out_status_d;
  logic [7:0] out_item_q, out_item_d;
  logic [4:0] out_found_q, out_found_d;
  logic [4:0] out_len_q, out_len_d;

  // Chain wiring.
  pble_pkg::cell_ctrl_t cell_ctrl;
  logic [PW-1:0]        cell_idx;
  logic [PW-1:0]        len_ext;
  logic [7:0]           data_w  [DEPTH];
  logic [7:0]           left_w  [DEPTH];
  logic [7:0]           right_w [DEPTH];
  logic [DEPTH-1:0]     match_w;

  logic accept;
  logic out_free;

  assign len_ext  = PW'(len_q);
  assign out_free = !out_valid_q || m_axis_tready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i] = 8'h00;
    end else begin : g_body
      assign left_w[i] = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w[i] = 8'h00;
    end else begin : g_inner
      assign right_w[i] = data_w[i+1];
    end

    pble_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .idx_i   (cell_idx),
      .len_i   (len_ext),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .data_o  (data_w[i]),
      .match_o (match_w[i])
    );
  end

  assign s_axis_tready = (state_q == pble_pkg::FSM_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] del_pos;
    logic          full;
    logic          empty;
    logic          hit;
    logic          last;
    logic          out_load;

    pos_ext = PW'(req_pos);
    del_pos = pos_ext;
    full    = (len_q == LW'(DEPTH));
    empty   = (len_q == '0);
    hit     = match_w[cnt_q];
    last    = (LW'(cnt_q) == len_q - LW'(1));

    state_d   = state_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    out_load  = 1'b0;
    cell_ctrl = '{op: pble_pkg::CELL_HOLD, item: req_item};
    cell_idx  = '0;

    out_status_d = out_status_q;
    out_item_d   = out_item_q;
    out_found_d  = out_found_q;
    out_len_d    = out_len_q;

    case (state_q)
      pble_pkg::FSM_IDLE: begin
        if (accept) begin
          out_load     = 1'b1;
          out_status_d = pble_pkg::STAT_OK;
          out_item_d   = 8'h00;
          out_found_d  = 5'd0;
          case (req_type)
            pble_pkg::REQ_INS_TAIL, pble_pkg::REQ_INS_HEAD, pble_pkg::REQ_INS_POS: begin
              if (req_type == pble_pkg::REQ_INS_TAIL) begin
                cell_idx = len_ext;
              end else if (req_type == pble_pkg::REQ_INS_HEAD) begin
                cell_idx = '0;
              end else begin
                cell_idx = pos_ext;
              end
              // The position check takes precedence over the full check.
              if (cell_idx > len_ext) begin
                out_status_d = pble_pkg::STAT_RANGE;
              end else if (full) begin
                out_status_d = pble_pkg::STAT_FULL;
              end else begin
                cell_ctrl.op = pble_pkg::CELL_INS;
                len_d        = len_q + LW'(1);
              end
            end
            pble_pkg::REQ_DEL_TAIL, pble_pkg::REQ_DEL_HEAD, pble_pkg::REQ_DEL_POS: begin
              if (req_type == pble_pkg::REQ_DEL_TAIL) begin
                del_pos = len_ext;
              end else if (req_type == pble_pkg::REQ_DEL_HEAD) begin
                del_pos = PW'(1);
              end
              cell_idx = del_pos - PW'(1);
              if (empty) begin
                out_status_d = pble_pkg::STAT_EMPTY;
              end else if (del_pos == '0 || del_pos > len_ext) begin
                out_status_d = pble_pkg::STAT_RANGE;
              end else begin
                cell_ctrl.op = pble_pkg::CELL_DEL;
                out_item_d   = data_w[cell_idx[AW-1:0]];
                len_d        = len_q - LW'(1);
              end
            end
            pble_pkg::REQ_SEARCH: begin
              if (empty) begin
                out_status_d = pble_pkg::STAT_EMPTY;
              end else begin
                // Latch hit flags in every cell and start the scan at the head.
                out_load     = 1'b0;
                cell_ctrl.op = pble_pkg::CELL_CMP;
                cnt_d        = '0;
                state_d      = pble_pkg::FSM_SCAN;
              end
            end
            default: begin
            end
          endcase
          out_len_d = 5'(len_d);
        end
      end
      pble_pkg::FSM_SCAN: begin
        if (hit || last) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_item_d   = 8'h00;
            out_len_d    = 5'(len_q);
            out_status_d = hit ? pble_pkg::STAT_OK : pble_pkg::STAT_MISS;
            out_found_d  = hit ? 5'(LW'(cnt_q) + LW'(1)) : 5'd0;
            state_d      = pble_pkg::FSM_IDLE;
          end
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      default: begin
        state_d = pble_pkg::FSM_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pble_pkg::FSM_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_item_q   <= out_item_d;
    out_found_q  <= out_found_d;
    out_len_q    <= out_len_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_len_q, out_found_q, out_item_q, out_status_q};

endmodule

/* hw/rtl/pble_cell.sv */
// One storage cell of the list chain: holds a byte and a search-hit flag.
`timescale 1ns / 1ps

module pble_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 5
) (
  input  logic                 clk_i,
  input  pble_pkg::cell_ctrl_t ctrl_i,
  input  logic [PW-1:0]        idx_i,
  input  logic [PW-1:0]        len_i,
  input  logic [7:0]           left_i,
  input  logic [7:0]           right_i,
  output logic [7:0]           data_o,
  output logic                 match_o
);

  logic [7:0] data_q, data_d;
  logic       match_q, match_d;
  logic [PW-1:0] my_idx;

  assign my_idx = PW'(INDEX);

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    case (ctrl_i.op)
      pble_pkg::CELL_INS: begin
        // Cells behind the insertion point take their left neighbor's byte.
        if (my_idx > idx_i) begin
          data_d = left_i;
        end else if (my_idx == idx_i) begin
          data_d = ctrl_i.item;
        end
      end
      pble_pkg::CELL_DEL: begin
        // Cells at and behind the victim take their right neighbor's byte.
        if (my_idx >= idx_i) begin
          data_d = right_i;
        end
      end
      pble_pkg::CELL_CMP: begin
        match_d = (data_q == ctrl_i.item) && (my_idx < len_i);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

/* tb/positional_byte_list_engine_top_tb.sv */
// Self-checking testbench for the positional byte list engine top level.
`timescale 1ns / 1ps

module positional_byte_list_engine_top_tb;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  // A search keeps the engine busy while it scans the list.
  localparam int SETTLE_CYCLES = DEPTH + 8;
  // Request code 7 is not decoded; the engine answers it without touching the list.
  localparam logic [2:0] REQ_NOP = 3'd7;

  // Slave-side tdata from bit 0: req_code, item, position.
  typedef struct packed {
    logic [4:0] position;
    logic [7:0] item;
    logic [2:0] req_code;
  } request_t;

  // Master-side tdata from bit 0: status, item_out, found_index, list_length, padding.
  typedef struct packed {
    logic [2:0] padding;
    logic [4:0] list_length;
    logic [4:0] found_index;
    logic [7:0] item_out;
    logic [2:0] status;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  logic [7:0] shadow_list[$];
  result_t    pending_results[$];
  int         fail_count;
  int         quiet_cycles;
  int         rx_hold_left;
  int         rx_gap_left;
  bit         idle_en;

  positional_byte_list_engine_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Applies one request to the shadow list and returns the result the engine owes for it.
  function automatic result_t list_apply(input request_t r);
    result_t res;
    int      n;
    int      idx;
    res = '0;
    res.status = pble_pkg::STAT_OK;
    n = shadow_list.size();
    case (r.req_code)
      pble_pkg::REQ_INS_TAIL, pble_pkg::REQ_INS_HEAD, pble_pkg::REQ_INS_POS: begin
        idx = (r.req_code == pble_pkg::REQ_INS_TAIL) ? n :
              (r.req_code == pble_pkg::REQ_INS_HEAD) ? 0 : int'(r.position);
        if (idx > n) begin
          res.status = pble_pkg::STAT_RANGE;
        end else if (n >= DEPTH) begin
          res.status = pble_pkg::STAT_FULL;
        end else if (idx == n) begin
          shadow_list.push_back(r.item);
        end else begin
          shadow_list.insert(idx, r.item);
        end
      end
      pble_pkg::REQ_DEL_TAIL, pble_pkg::REQ_DEL_HEAD, pble_pkg::REQ_DEL_POS: begin
        idx = (r.req_code == pble_pkg::REQ_DEL_TAIL) ? n :
              (r.req_code == pble_pkg::REQ_DEL_HEAD) ? 1 : int'(r.position);
        if (n == 0) begin
          res.status = pble_pkg::STAT_EMPTY;
        end else if (idx == 0 || idx > n) begin
          res.status = pble_pkg::STAT_RANGE;
        end else begin
          res.item_out = shadow_list[idx-1];
          shadow_list.delete(idx - 1);
        end
      end
      pble_pkg::REQ_SEARCH: begin
        if (n == 0) begin
          res.status = pble_pkg::STAT_EMPTY;
        end else begin
          res.status = pble_pkg::STAT_MISS;
          // Walk from the tail so that the first match from the head is the one kept.
          for (int i = n - 1; i >= 0; i--) begin
            if (shadow_list[i] == r.item) begin
              res.status = pble_pkg::STAT_OK;
              res.found_index = 5'(i + 1);
            end
          end
        end
      end
      default: ;
    endcase
    res.list_length = 5'(shadow_list.size());
    return res;
  endfunction

  function automatic void compare_result(input result_t want, input result_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.item_out !== want.item_out) begin
      $error("item_out: expected %0d, got %0d", want.item_out, got.item_out);
      fail_count++;
    end
    if (got.found_index !== want.found_index) begin
      $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
      fail_count++;
    end
    if (got.list_length !== want.list_length) begin
      $error("list_length: expected %0d, got %0d", want.list_length, got.list_length);
      fail_count++;
    end
    if (got.padding !== want.padding) begin
      $error("padding: expected %0d, got %0d", want.padding, got.padding);
      fail_count++;
    end
  endfunction

  // Beat monitor: the result beat is checked before the request of the same edge is
  // predicted, since a result can never belong to a request accepted at that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          compare_result(pending_results.pop_front(), m_axis_tdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(list_apply(s_axis_tdata));
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Result sink: a long hold-off when asked, otherwise short random stalls while idle_en is set.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else if (rx_gap_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rx_gap_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offers one request beat and returns at the edge where it is accepted.
  task automatic send_request(input logic [2:0] code, input logic [7:0] item,
                              input logic [4:0] position);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {position, item, code};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the request side quiet until every result has come back.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed requests whose positions track the list length; grow biases
  // toward inserts so the length sweeps between empty and full.
  task automatic send_random(input bit grow);
    int         n;
    int         pick;
    logic [2:0] code;
    logic [7:0] item;
    logic [4:0] position;
    n = shadow_list.size();
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      code = REQ_NOP;
    end else if (pick < 16) begin
      code = pble_pkg::REQ_SEARCH;
    end else if (pick < (grow ? 70 : 45)) begin
      code = 3'($urandom_range(pble_pkg::REQ_INS_TAIL, pble_pkg::REQ_INS_POS));
    end else begin
      code = 3'($urandom_range(pble_pkg::REQ_DEL_TAIL, pble_pkg::REQ_DEL_POS));
    end
    // A narrow alphabet now and then leaves duplicates for the search to sort out.
    item = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    if (code == pble_pkg::REQ_SEARCH && n > 0 && $urandom_range(0, 2) != 0) begin
      item = shadow_list[$urandom_range(0, n - 1)];
    end
    position = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, n + 1));
    send_request(code, item, position);
  endtask

  task automatic test_empty_and_small();
    send_request(pble_pkg::REQ_DEL_TAIL, 8'h00, 5'd0);
    send_request(pble_pkg::REQ_DEL_HEAD, 8'hFF, 5'd1);
    send_request(pble_pkg::REQ_DEL_POS, 8'h00, 5'd1);
    send_request(pble_pkg::REQ_DEL_POS, 8'h00, 5'd0);
    send_request(pble_pkg::REQ_SEARCH, 8'h00, 5'd0);
    send_request(REQ_NOP, 8'h00, 5'd0);
    send_request(pble_pkg::REQ_INS_POS, 8'h11, 5'd1);
    send_request(pble_pkg::REQ_INS_POS, 8'h22, 5'd31);
    send_request(pble_pkg::REQ_INS_POS, 8'h00, 5'd0);
    send_request(pble_pkg::REQ_INS_HEAD, 8'hFF, 5'd0);
    send_request(pble_pkg::REQ_INS_TAIL, 8'h80, 5'd0);
    send_request(pble_pkg::REQ_INS_POS, 8'h01, 5'd2);
    send_request(pble_pkg::REQ_SEARCH, 8'hFF, 5'd0);
    send_request(pble_pkg::REQ_SEARCH, 8'h80, 5'd0);
    send_request(pble_pkg::REQ_SEARCH, 8'h42, 5'd0);
    send_request(pble_pkg::REQ_DEL_POS, 8'h00, 5'd0);
    send_request(pble_pkg::REQ_DEL_POS, 8'h00, 5'd5);
    send_request(pble_pkg::REQ_DEL_POS, 8'h00, 5'd2);
    send_request(pble_pkg::REQ_DEL_HEAD, 8'h00, 5'd0);
    send_request(pble_pkg::REQ_DEL_TAIL, 8'h00, 5'd0);
    send_request(REQ_NOP, 8'hFF, 5'd31);
  endtask

  // Fills the list to DEPTH, then probes every insert flavor, searches, deletes and the far positions.
  task automatic test_full_list();
    int         count;
    int         kind;
    bit         hit;
    logic [7:0] absent;
    wait_all_results();
    count = shadow_list.size();
    while (count < DEPTH) begin
      kind = $urandom_range(0, 2);
      send_request(3'(pble_pkg::REQ_INS_TAIL + kind), 8'($urandom_range(0, 255)),
                   5'($urandom_range(0, count)));
      count++;
    end
    wait_all_results();
    absent = 8'h00;
    for (int v = 255; v >= 0; v--) begin
      hit = 1'b0;
      foreach (shadow_list[k]) if (shadow_list[k] == v) hit = 1'b1;
      if (!hit) absent = 8'(v);
    end
    send_request(pble_pkg::REQ_INS_TAIL, 8'h5A, 5'd0);
    send_request(pble_pkg::REQ_INS_HEAD, 8'hA5, 5'd0);
    send_request(pble_pkg::REQ_INS_POS, 8'h5A, 5'd16);
    // On a full list the position check still wins over the full check.
    send_request(pble_pkg::REQ_INS_POS, 8'hA5, 5'd17);
    send_request(pble_pkg::REQ_INS_POS, 8'hA5, 5'd31);
    send_request(pble_pkg::REQ_SEARCH, shadow_list[DEPTH-1], 5'd0);
    send_request(pble_pkg::REQ_SEARCH, absent, 5'd0);
    send_request(REQ_NOP, 8'h00, 5'd16);
    send_request(pble_pkg::REQ_DEL_POS, 8'h00, 5'd17);
    send_request(pble_pkg::REQ_DEL_POS, 8'h00, 5'd16);
    send_request(pble_pkg::REQ_DEL_POS, 8'h00, 5'd16);
  endtask

  task automatic test_random_mix(input int items);
    bit grow;
    grow = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) idle_en = ($urandom_range(0, 3) != 0);
      if (shadow_list.size() >= DEPTH - 1 && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (shadow_list.size() <= 1) grow = 1'b1;
      send_random(grow);
    end
  endtask

  // The sink holds off for a long stretch while requests keep coming, so the
  // result register fills and the engine has to stall its request side.
  task automatic test_output_stall();
    idle_en = 1'b0;
    rx_hold_left = 48;
    repeat (30) send_random($urandom_range(0, 1));
    idle_en = 1'b1;
  endtask

  task automatic test_full_rate(input int items);
    idle_en = 1'b0;
    for (int i = 0; i < items; i++) send_random(shadow_list.size() < DEPTH / 2);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    fail_count    = 0;
    quiet_cycles  = 0;
    rx_hold_left  = 0;
    rx_gap_left   = 0;
    idle_en       = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_small();
    test_full_list();
    wait_all_results();
    test_random_mix(1100);
    wait_all_results();
    test_output_stall();
    wait_all_results();
    test_full_list();
    test_full_rate(420);
    wait_all_results();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
